/* hdl/linear_regression_gradient_descent_assert.svh */
// Assertion macros shared by the gradient descent RTL.
// Depends on nothing; the including module supplies clk_i and rst_ni.
`ifndef LINEAR_REGRESSION_GRADIENT_DESCENT_ASSERT_SVH
`define LINEAR_REGRESSION_GRADIENT_DESCENT_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define LRGD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lrgd assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define LRGD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lrgd assertion failed");

`endif

/* hdl/lrgd_pkg.sv */
// Constants and saturating arithmetic helpers for the gradient descent block.
// Used by linear_regression_gradient_descent; depends on nothing.
package lrgd_pkg;

  localparam int MAX_ROWS     = 256;
  localparam int MAX_FEATURES = 8;
  localparam int DATA_WIDTH   = 32;
  localparam int GAIN_BITS    = 48;
  localparam int FRAC_BITS    = 16;
  localparam int ROW_W        = 8;
  localparam int COL_W        = 3;
  localparam int FEAT_ADDR_W  = ROW_W + COL_W;

  // Input kinds carried in tuser.
  localparam logic [1:0] KIND_FEATURE = 2'd0;
  localparam logic [1:0] KIND_TARGET  = 2'd1;
  localparam logic [1:0] KIND_COEF    = 2'd2;
  localparam logic [1:0] KIND_RUN     = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_ROWS  = 2'd0;
  localparam logic [1:0] REG_FEATS = 2'd1;
  localparam logic [1:0] REG_ITERS = 2'd2;
  localparam logic [1:0] REG_GAIN  = 2'd3;

  // 64-bit add that clamps at the signed limits.
  function automatic logic signed [63:0] sat_add64(logic signed [63:0] a,
                                                   logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sat_add64 = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sat_add64 = s[63:0];
    end
  endfunction

  // Clamp a 64-bit value into the 32-bit data range.
  function automatic logic signed [31:0] sat_data64(logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) begin
      sat_data64 = 32'sh7FFF_FFFF;
    end else if (v < -64'sh8000_0000) begin
      sat_data64 = 32'sh8000_0000;
    end else begin
      sat_data64 = v[31:0];
    end
  endfunction

endpackage

/* hdl/linear_regression_gradient_descent.sv */
// Batch gradient descent for linear regression in Q16.16 fixed point.
// Depends on lrgd_pkg, lrgd_ram and linear_regression_gradient_descent_assert.svh.
//
// Usage: load transactions on the slave stream fill the sample matrix, the
// target column and the initial coefficients, one element each. tuser holds
// the kind; after a load the block is ready again at once.
// A run transaction performs iteration_count batch steps and then sends one
// master transaction per coefficient in use, tlast on the final one.
// Per step, each row reads, multiplies and accumulates feature by feature for
// the prediction, forms the residual, then does the same per feature for the
// gradient, using 32x32 multiplies; each coefficient update then loads, runs a
// bit-serial 64x48 gain multiply and writes the result back.
// Unless feature_count is zero, tready stays low from the run transaction until
// the last result is taken; while the receiver stalls, the current result holds.
// Configuration writes are taken in any cycle but are meant only for idle.
// Reset clears the control state, the accumulators and the registers to
// their defaults; the stores hold nothing defined until written.
module linear_regression_gradient_descent (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // row[7:0], column[10:8], value[42:11], zeros
  input  logic [1:0]  s_axis_tuser,  // kind[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // coefficient[31:0], coefficient_index[34:32], zeros
  output logic        m_axis_tlast
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_STEP     = 4'd1;
  localparam logic [3:0] ST_PRED_RD  = 4'd2;
  localparam logic [3:0] ST_PRED_MUL = 4'd3;
  localparam logic [3:0] ST_PRED_ACC = 4'd4;
  localparam logic [3:0] ST_RES      = 4'd5;
  localparam logic [3:0] ST_GRAD_RD  = 4'd6;
  localparam logic [3:0] ST_GRAD_MUL = 4'd7;
  localparam logic [3:0] ST_GRAD_ACC = 4'd8;
  localparam logic [3:0] ST_UPD_LD   = 4'd9;
  localparam logic [3:0] ST_UPD_MUL  = 4'd10;
  localparam logic [3:0] ST_UPD_WR   = 4'd11;
  localparam logic [3:0] ST_OUT      = 4'd12;

  logic [3:0]  state_q, state_d;
  logic [8:0]  rows_cfg_q;
  logic [3:0]  feats_cfg_q;
  logic [15:0] iters_q;
  logic [47:0] gain_q;
  logic [7:0]  row_q, row_d;
  logic [2:0]  col_q, col_d;
  logic [15:0] iter_q, iter_d;
  logic [5:0]  bit_q, bit_d;
  logic signed [63:0] pred_q, pred_d;
  logic signed [31:0] res_q, res_d;
  logic signed [63:0] prod_q, prod_d;
  logic signed [63:0] acc_q [lrgd_pkg::MAX_FEATURES];
  logic signed [63:0] acc_d [lrgd_pkg::MAX_FEATURES];
  logic signed [31:0] coef_q [lrgd_pkg::MAX_FEATURES];
  logic [63:0] mag_q, mag_d;
  logic [63:0] ph_q, ph_d;
  logic        neg_q, neg_d;
  logic        sticky_q, sticky_d;

  logic [8:0]  rows;
  logic [3:0]  feats;
  logic        last_col;
  logic        last_row;
  logic [lrgd_pkg::ROW_W-1:0] in_row;
  logic [lrgd_pkg::COL_W-1:0] in_col;
  logic signed [31:0] in_value;
  logic        in_fire;
  logic [31:0] feat_rdata;
  logic [31:0] target_rdata;
  logic signed [63:0] prod_shifted;
  logic [64:0] ser_sum;
  logic [40:0] q_capped;
  logic signed [43:0] scaled;
  logic signed [43:0] new_coef;
  logic        coef_we;

  assign rows  = (rows_cfg_q > 9'(lrgd_pkg::MAX_ROWS)) ? 9'(lrgd_pkg::MAX_ROWS) : rows_cfg_q;
  assign feats = (feats_cfg_q > 4'(lrgd_pkg::MAX_FEATURES))
               ? 4'(lrgd_pkg::MAX_FEATURES) : feats_cfg_q;
  assign last_col = ({1'b0, col_q} == (feats - 4'd1));
  assign last_row = ({1'b0, row_q} == (rows - 9'd1));

  assign in_row   = s_axis_tdata[7:0];
  assign in_col   = s_axis_tdata[10:8];
  assign in_value = s_axis_tdata[42:11];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q  <= 9'd1;
      feats_cfg_q <= 4'd1;
      iters_q     <= 16'd1;
      gain_q      <= 48'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        lrgd_pkg::REG_ROWS:  rows_cfg_q  <= cfg_data_i[8:0];
        lrgd_pkg::REG_FEATS: feats_cfg_q <= cfg_data_i[3:0];
        lrgd_pkg::REG_ITERS: iters_q     <= cfg_data_i[15:0];
        lrgd_pkg::REG_GAIN:  gain_q      <= cfg_data_i[47:0];
        default: ;
      endcase
    end
  end

  // Sample matrix, addressed by {row, column}.
  lrgd_ram #(
    .WIDTH(lrgd_pkg::DATA_WIDTH),
    .DEPTH(lrgd_pkg::MAX_ROWS * lrgd_pkg::MAX_FEATURES)
  ) u_feature_ram (
    .clk_i  (clk_i),
    .we_i   (in_fire && (s_axis_tuser == lrgd_pkg::KIND_FEATURE)),
    .waddr_i({in_row, in_col}),
    .wdata_i(in_value),
    .raddr_i({row_q, col_q}),
    .rdata_o(feat_rdata)
  );

  // Target column; the read address follows the current row.
  lrgd_ram #(
    .WIDTH(lrgd_pkg::DATA_WIDTH),
    .DEPTH(lrgd_pkg::MAX_ROWS)
  ) u_target_ram (
    .clk_i  (clk_i),
    .we_i   (in_fire && (s_axis_tuser == lrgd_pkg::KIND_TARGET)),
    .waddr_i(in_row),
    .wdata_i(in_value),
    .raddr_i(row_q),
    .rdata_o(target_rdata)
  );

  // Product truncated toward minus infinity back to Q16.16.
  assign prod_shifted = prod_q >>> lrgd_pkg::FRAC_BITS;

  // One step of the right-shifting serial multiply of |g| by the gain.
  assign ser_sum = {1'b0, ph_q} + (gain_q[bit_q] ? {1'b0, mag_q} : 65'd0);

  assign q_capped = (ph_q > 64'h100_0000_0000) ? 41'h100_0000_0000 : ph_q[40:0];
  assign scaled   = neg_q ? (-{3'b000, q_capped} - 44'(sticky_q)) : {3'b000, q_capped};
  assign new_coef = 44'(coef_q[col_q]) - scaled;
  assign coef_we  = (state_q == ST_UPD_WR);

  always_comb begin
    state_d  = state_q;
    row_d    = row_q;
    col_d    = col_q;
    iter_d   = iter_q;
    bit_d    = bit_q;
    pred_d   = pred_q;
    res_d    = res_q;
    prod_d   = prod_q;
    mag_d    = mag_q;
    ph_d     = ph_q;
    neg_d    = neg_q;
    sticky_d = sticky_q;
    acc_d    = acc_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && (s_axis_tuser == lrgd_pkg::KIND_RUN)) begin
          iter_d = 16'd0;
          col_d  = 3'd0;
          if (feats == 4'd0) begin
            state_d = ST_IDLE;
          end else if (iters_q == 16'd0) begin
            state_d = ST_OUT;
          end else begin
            state_d = ST_STEP;
          end
        end
      end
      ST_STEP: begin
        for (int j = 0; j < lrgd_pkg::MAX_FEATURES; j++) begin
          acc_d[j] = 64'sd0;
        end
        row_d  = 8'd0;
        col_d  = 3'd0;
        pred_d = 64'sd0;
        state_d = (rows == 9'd0) ? ST_UPD_LD : ST_PRED_RD;
      end
      ST_PRED_RD: begin
        state_d = ST_PRED_MUL;
      end
      ST_PRED_MUL: begin
        prod_d  = 64'($signed(feat_rdata) * coef_q[col_q]);
        state_d = ST_PRED_ACC;
      end
      ST_PRED_ACC: begin
        pred_d = lrgd_pkg::sat_add64(pred_q, prod_shifted);
        if (last_col) begin
          state_d = ST_RES;
        end else begin
          col_d   = col_q + 3'd1;
          state_d = ST_PRED_RD;
        end
      end
      ST_RES: begin
        res_d   = lrgd_pkg::sat_data64(
                    lrgd_pkg::sat_add64(pred_q, -64'($signed(target_rdata))));
        col_d   = 3'd0;
        state_d = ST_GRAD_RD;
      end
      ST_GRAD_RD: begin
        state_d = ST_GRAD_MUL;
      end
      ST_GRAD_MUL: begin
        prod_d  = 64'($signed(feat_rdata) * res_q);
        state_d = ST_GRAD_ACC;
      end
      ST_GRAD_ACC: begin
        acc_d[col_q] = lrgd_pkg::sat_add64(acc_q[col_q], prod_shifted);
        col_d = last_col ? 3'd0 : col_q + 3'd1;
        if (!last_col) begin
          state_d = ST_GRAD_RD;
        end else if (last_row) begin
          state_d = ST_UPD_LD;
        end else begin
          row_d   = row_q + 8'd1;
          pred_d  = 64'sd0;
          state_d = ST_PRED_RD;
        end
      end
      ST_UPD_LD: begin
        neg_d    = acc_q[col_q][63];
        mag_d    = acc_q[col_q][63] ? (64'd0 - acc_q[col_q]) : acc_q[col_q];
        ph_d     = 64'd0;
        sticky_d = 1'b0;
        bit_d    = 6'd0;
        state_d  = ST_UPD_MUL;
      end
      ST_UPD_MUL: begin
        sticky_d = sticky_q | ser_sum[0];
        ph_d     = ser_sum[64:1];
        bit_d    = bit_q + 6'd1;
        if (bit_q == 6'(lrgd_pkg::GAIN_BITS - 1)) begin
          state_d = ST_UPD_WR;
        end
      end
      ST_UPD_WR: begin
        if (!last_col) begin
          col_d   = col_q + 3'd1;
          state_d = ST_UPD_LD;
        end else begin
          col_d  = 3'd0;
          iter_d = iter_q + 16'd1;
          state_d = ((iter_q + 16'd1) == iters_q) ? ST_OUT : ST_STEP;
        end
      end
      ST_OUT: begin
        if (m_axis_tready) begin
          col_d   = last_col ? 3'd0 : col_q + 3'd1;
          state_d = last_col ? ST_IDLE : ST_OUT;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q   <= 8'd0;
      col_q   <= 3'd0;
      iter_q  <= 16'd0;
      bit_q   <= 6'd0;
      for (int j = 0; j < lrgd_pkg::MAX_FEATURES; j++) begin
        acc_q[j] <= 64'sd0;
      end
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      iter_q  <= iter_d;
      bit_q   <= bit_d;
      acc_q   <= acc_d;
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    pred_q   <= pred_d;
    res_q    <= res_d;
    prod_q   <= prod_d;
    mag_q    <= mag_d;
    ph_q     <= ph_d;
    neg_q    <= neg_d;
    sticky_q <= sticky_d;
    if (in_fire && (s_axis_tuser == lrgd_pkg::KIND_COEF)) begin
      coef_q[in_col] <= in_value;
    end else if (coef_we) begin
      coef_q[col_q] <= lrgd_pkg::sat_data64(64'(new_coef));
    end
  end

  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = {5'd0, col_q, coef_q[col_q]};
  assign m_axis_tlast  = last_col;

  `include "linear_regression_gradient_descent_assert.svh"

  `LRGD_ASSERT(a_ready_excludes_result, !(s_axis_tready && m_axis_tvalid))
  `LRGD_ASSERT(a_result_index_in_use, !m_axis_tvalid || ({1'b0, col_q} < feats))
  `LRGD_ASSERT_NEXT(a_ready_after_last, m_axis_tvalid && m_axis_tready && m_axis_tlast,
                    s_axis_tready)
  `LRGD_ASSERT(a_serial_bit_range, (state_q != ST_UPD_MUL) || (bit_q < 6'd48))

endmodule

/* hdl/lrgd_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module lrgd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* verif/tb_linear_regression_gradient_descent.sv */
// Self-checking testbench for linear_regression_gradient_descent.
// It depends on lrgd_pkg and on the RTL only: a built-in fixed-point predictor
// predicts each coefficient stream, and random stalls are applied on both sides.
`timescale 1ns / 100ps

module tb_linear_regression_gradient_descent;

  // Clock, reset and block ports.
  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [47:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // row[7:0], column[10:8], value[42:11], zeros
  logic [1:0]  s_axis_tuser;   // kind[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // coefficient[31:0], coefficient_index[34:32], zeros
  logic        m_axis_tlast;

  linear_regression_gradient_descent uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // One element or run command on the slave stream.
  typedef struct packed {
    logic [1:0]                  kind;
    logic [lrgd_pkg::ROW_W-1:0]  row;
    logic [lrgd_pkg::COL_W-1:0]  column;
    logic signed [31:0]          value;
  } load_item_t;

  // One coefficient transaction on the master stream.
  typedef struct packed {
    logic signed [31:0]          coef;
    logic [lrgd_pkg::COL_W-1:0]  index;
    logic                        last;
  } coef_result_t;

  localparam int CYCLE_LIMIT = 2_000_000;

  load_item_t   pending_items[$];
  coef_result_t expected_coefs[$];

  // Register copies that the predictor works from.
  logic [8:0]  rows_reg;
  logic [3:0]  feats_reg;
  logic [15:0] iters_reg;
  logic [47:0] gain_reg;

  // Predictor copy of the stores and the stimulus-side record of what was loaded.
  longint feat_mem [lrgd_pkg::MAX_ROWS][lrgd_pkg::MAX_FEATURES];
  longint tgt_mem  [lrgd_pkg::MAX_ROWS];
  longint coef_mem [lrgd_pkg::MAX_FEATURES];
  bit     feat_loaded [lrgd_pkg::MAX_ROWS][lrgd_pkg::MAX_FEATURES];
  bit     tgt_loaded  [lrgd_pkg::MAX_ROWS];
  bit     coef_loaded [lrgd_pkg::MAX_FEATURES];

  int  send_idle_pct;
  int  recv_idle_pct;
  bit  s_fire;
  int  cycle_count;
  int  mismatch_count;
  int  load_count;
  int  run_count;
  int  result_count;
  int  queued_count;

  // ---------------------------------------------------------------------------
  // Fixed-point helpers of the predictor.
  // ---------------------------------------------------------------------------

  // 64-bit addition clamped at the signed limits.
  function automatic longint add_clamp64(longint a, longint b);
    longint s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sh7FFF_FFFF) begin
      return 64'sh7FFF_FFFF;
    end else if (v < -64'sh8000_0000) begin
      return -64'sh8000_0000;
    end
    return v;
  endfunction

  // Q16.16 product, floored back to Q16.16.
  function automatic longint fixed_mul(longint a, longint b);
    longint p;
    p = a * b;
    return p >>> lrgd_pkg::FRAC_BITS;
  endfunction

  // floor(g * gain / 2^48), magnitude capped at 2^40.
  function automatic longint gain_scale(longint g, logic [47:0] gain);
    logic [63:0]  mag;
    logic [111:0] prod;
    logic [63:0]  q;
    logic         rem;
    mag  = g[63] ? 64'd0 - 64'(g) : 64'(g);
    prod = {48'd0, mag} * {64'd0, gain};
    q    = prod[111:48];
    rem  = |prod[47:0];
    if (q > (64'd1 << 40)) q = 64'd1 << 40;
    if (g[63]) return -longint'(q) - longint'(rem);
    return longint'(q);
  endfunction

  // Applies one accepted transaction to the predictor; a run queues its results.
  task automatic predict_coefficients(load_item_t it);
    int     n_rows;
    int     n_feats;
    longint grad [lrgd_pkg::MAX_FEATURES];
    longint pred;
    longint resid;
    coef_result_t res;
    n_rows  = (rows_reg > lrgd_pkg::MAX_ROWS) ? lrgd_pkg::MAX_ROWS : rows_reg;
    n_feats = (feats_reg > lrgd_pkg::MAX_FEATURES) ? lrgd_pkg::MAX_FEATURES : feats_reg;
    case (it.kind)
      lrgd_pkg::KIND_FEATURE: feat_mem[it.row][it.column] = it.value;
      lrgd_pkg::KIND_TARGET:  tgt_mem[it.row] = it.value;
      lrgd_pkg::KIND_COEF:    coef_mem[it.column] = it.value;
      default: begin
        // Each step reads only the old coefficients, then updates them all.
        for (int k = 0; k < iters_reg; k++) begin
          for (int j = 0; j < n_feats; j++) grad[j] = 0;
          for (int r = 0; r < n_rows; r++) begin
            pred = 0;
            for (int j = 0; j < n_feats; j++) begin
              pred = add_clamp64(pred, fixed_mul(feat_mem[r][j], coef_mem[j]));
            end
            resid = clamp32(add_clamp64(pred, -tgt_mem[r]));
            for (int j = 0; j < n_feats; j++) begin
              grad[j] = add_clamp64(grad[j], fixed_mul(feat_mem[r][j], resid));
            end
          end
          for (int j = 0; j < n_feats; j++) begin
            coef_mem[j] = clamp32(coef_mem[j] - gain_scale(grad[j], gain_reg));
          end
        end
        for (int j = 0; j < n_feats; j++) begin
          res.coef  = coef_mem[j][31:0];
          res.index = j[lrgd_pkg::COL_W-1:0];
          res.last  = (j == n_feats - 1);
          expected_coefs.push_back(res);
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Clock, reset and cycle limit.
  // ---------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // The timeout is a plain cycle counter; it ends the run on its own.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, expected_coefs.size());
      $display("tb_linear_regression_gradient_descent: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: presents queued items at the falling edge, with random gaps.
  // s_fire records at the rising edge that the held item was taken.
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    s_fire <= s_axis_tvalid && s_axis_tready && rst_ni;
    if (s_axis_tvalid && s_axis_tready && rst_ni) begin
      predict_coefficients(load_item_t'({s_axis_tuser, s_axis_tdata[7:0],
                                         s_axis_tdata[10:8], s_axis_tdata[42:11]}));
      if (s_axis_tuser == lrgd_pkg::KIND_RUN) run_count <= run_count + 1;
      else load_count <= load_count + 1;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || s_fire)) begin
      // The previous item is gone (or none was shown); decide on the next one.
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        load_item_t it;
        it = pending_items.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.kind;
        s_axis_tdata  <= {5'd0, it.value, it.column, it.row};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver stalls are drawn fresh every cycle.
  always @(negedge clk_i) begin
    m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Monitor: compares every result transaction with the oldest expectation.
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      coef_result_t want;
      result_count <= result_count + 1;
      if (expected_coefs.size() == 0) begin
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= 10) begin
          $display("unexpected result: coef %h index %0d last %0b",
                   m_axis_tdata[31:0], m_axis_tdata[34:32], m_axis_tlast);
        end
      end else begin
        want = expected_coefs.pop_front();
        if (m_axis_tdata[31:0] !== want.coef || m_axis_tdata[34:32] !== want.index ||
            m_axis_tlast !== want.last) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected coef %h index %0d last %0b, got %h %0d %0b",
                     want.coef, want.index, want.last, m_axis_tdata[31:0],
                     m_axis_tdata[34:32], m_axis_tlast);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Register writes happen only while the block is idle.
  task automatic write_reg(logic [1:0] idx, logic [47:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      lrgd_pkg::REG_ROWS:  rows_reg  = data[8:0];
      lrgd_pkg::REG_FEATS: feats_reg = data[3:0];
      lrgd_pkg::REG_ITERS: iters_reg = data[15:0];
      default:             gain_reg  = data;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_item(logic [1:0] kind, int row, int col, logic signed [31:0] val);
    load_item_t it;
    it.kind   = kind;
    it.row    = row[lrgd_pkg::ROW_W-1:0];
    it.column = col[lrgd_pkg::COL_W-1:0];
    it.value  = val;
    case (kind)
      lrgd_pkg::KIND_FEATURE: feat_loaded[it.row][it.column] = 1'b1;
      lrgd_pkg::KIND_TARGET:  tgt_loaded[it.row] = 1'b1;
      lrgd_pkg::KIND_COEF:    coef_loaded[it.column] = 1'b1;
      default: ;
    endcase
    pending_items.push_back(it);
    queued_count++;
  endtask

  // Mostly modest Q16.16 values so descent stays meaningful, sometimes full range.
  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(9))
      0:       return $urandom;
      1:       return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  // Queues a run, first loading any entry it would read that was never loaded.
  task automatic queue_run();
    int n_rows;
    int n_feats;
    n_rows  = (rows_reg > lrgd_pkg::MAX_ROWS) ? lrgd_pkg::MAX_ROWS : rows_reg;
    n_feats = (feats_reg > lrgd_pkg::MAX_FEATURES) ? lrgd_pkg::MAX_FEATURES : feats_reg;
    for (int r = 0; r < n_rows; r++) begin
      if (!tgt_loaded[r]) begin
        queue_item(lrgd_pkg::KIND_TARGET, r, $urandom_range(7), rand_value());
      end
      for (int j = 0; j < n_feats; j++) begin
        if (!feat_loaded[r][j]) queue_item(lrgd_pkg::KIND_FEATURE, r, j, rand_value());
      end
    end
    for (int j = 0; j < n_feats; j++) begin
      if (!coef_loaded[j]) queue_item(lrgd_pkg::KIND_COEF, $urandom_range(255), j, rand_value());
    end
    queue_item(lrgd_pkg::KIND_RUN, $urandom_range(255), $urandom_range(7), $urandom);
  endtask

  // Waits until everything queued is taken and every expected result has
  // come, then for the block's ready, so that a run without results is over.
  task automatic drain();
    while (pending_items.size() != 0 || s_axis_tvalid || expected_coefs.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  // Idling follows the share of stimulus already queued.
  task automatic pick_idling(int target);
    if (queued_count < target / 3) begin
      send_idle_pct = 13;
      recv_idle_pct = 58;
    end else if (queued_count < 2 * target / 3) begin
      send_idle_pct = 58;
      recv_idle_pct = 13;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------

  initial begin
    int n_rows;
    int n_feats;
    int n_loads;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = lrgd_pkg::REG_ROWS;
    cfg_data_i     = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = lrgd_pkg::KIND_FEATURE;
    m_axis_tready  = 1'b0;
    s_fire         = 1'b0;
    cycle_count    = 0;
    mismatch_count = 0;
    load_count     = 0;
    run_count      = 0;
    result_count   = 0;
    queued_count   = 0;
    send_idle_pct  = 13;
    recv_idle_pct  = 58;
    rows_reg  = 9'd1;
    feats_reg = 4'd1;
    iters_reg = 16'd1;
    gain_reg  = '0;
    for (int r = 0; r < lrgd_pkg::MAX_ROWS; r++) begin
      tgt_mem[r] = 0;
      tgt_loaded[r] = 1'b0;
      for (int j = 0; j < lrgd_pkg::MAX_FEATURES; j++) begin
        feat_mem[r][j] = 0;
        feat_loaded[r][j] = 1'b0;
      end
    end
    for (int j = 0; j < lrgd_pkg::MAX_FEATURES; j++) begin
      coef_mem[j] = 0;
      coef_loaded[j] = 1'b0;
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. A run straight after reset uses the default registers.
    queue_item(lrgd_pkg::KIND_FEATURE, 0, 0, 32'sh0001_0000);
    queue_item(lrgd_pkg::KIND_TARGET, 0, 5, 32'sh0002_0000);
    queue_item(lrgd_pkg::KIND_COEF, 255, 0, 32'sh0000_8000);
    queue_run();
    // Extremes of every field, including a column beyond feature_count.
    queue_item(lrgd_pkg::KIND_FEATURE, 255, 7, 32'sh7FFF_FFFF);
    queue_item(lrgd_pkg::KIND_TARGET, 255, 7, 32'sh8000_0000);
    queue_item(lrgd_pkg::KIND_COEF, 170, 7, -32'sd1);
    queue_item(lrgd_pkg::KIND_FEATURE, 85, 2, 32'sh5555_AAAA);
    drain();

    // Small step with a real gain; then iteration_count zero just echoes.
    write_reg(lrgd_pkg::REG_ROWS, 48'd2);
    write_reg(lrgd_pkg::REG_FEATS, 48'd2);
    write_reg(lrgd_pkg::REG_ITERS, 48'd3);
    write_reg(lrgd_pkg::REG_GAIN, 48'h0400_0000_0000);
    queue_run();
    drain();
    write_reg(lrgd_pkg::REG_ITERS, 48'd0);
    queue_run();
    drain();

    // Full gain, and large values that drive the arithmetic into saturation.
    write_reg(lrgd_pkg::REG_ITERS, 48'hFFFF);
    write_reg(lrgd_pkg::REG_ITERS, 48'd2);
    write_reg(lrgd_pkg::REG_GAIN, 48'hFFFF_FFFF_FFFF);
    queue_item(lrgd_pkg::KIND_FEATURE, 1, 1, 32'sh8000_0000);
    queue_item(lrgd_pkg::KIND_TARGET, 1, 0, 32'sh7FFF_FFFF);
    queue_run();
    drain();

    // Zero rows gives zero gradients; zero features gives no results at all.
    write_reg(lrgd_pkg::REG_ROWS, 48'd0);
    queue_run();
    drain();
    write_reg(lrgd_pkg::REG_FEATS, 48'd0);
    queue_run();
    drain();
    // Oversized feature_count clamps to the maximum.
    write_reg(lrgd_pkg::REG_ROWS, 48'd3);
    write_reg(lrgd_pkg::REG_FEATS, 48'd15);
    write_reg(lrgd_pkg::REG_ITERS, 48'd1);
    write_reg(lrgd_pkg::REG_GAIN, 48'h0010_0000_0000);
    queue_run();
    drain();

    // Random part: well-formed load sets over random settings, some noise,
    // then one or two runs. Every phase drains before its register writes,
    // which also makes the sender wait for all pending results.
    while (queued_count < 300) begin
      pick_idling(300);
      n_rows  = $urandom_range(1, 8);
      n_feats = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(1, 8);
      write_reg(lrgd_pkg::REG_ROWS, 48'(n_rows));
      write_reg(lrgd_pkg::REG_FEATS, 48'(n_feats));
      write_reg(lrgd_pkg::REG_ITERS, 48'($urandom_range(0, 4)));
      write_reg(lrgd_pkg::REG_GAIN, ($urandom_range(3) == 0) ? 48'({$urandom, $urandom}) :
                                    48'($urandom_range(32'h00FF_FFFF)) << 16);
      n_rows  = (n_rows > lrgd_pkg::MAX_ROWS) ? lrgd_pkg::MAX_ROWS : n_rows;
      n_feats = (n_feats > lrgd_pkg::MAX_FEATURES) ? lrgd_pkg::MAX_FEATURES : n_feats;
      n_loads = $urandom_range(4, 14);
      for (int i = 0; i < n_loads; i++) begin
        if ($urandom_range(4) == 0 || n_rows == 0 || n_feats == 0) begin
          queue_item(2'($urandom_range(2)), $urandom_range(255), $urandom_range(7), $urandom);
        end else begin
          queue_item(2'($urandom_range(2)), $urandom_range(n_rows - 1),
                     $urandom_range(n_feats - 1), rand_value());
        end
      end
      queue_run();
      if ($urandom_range(2) == 0) queue_run();
      drain();
    end

    // One run over a longer row range, feature_count one to keep it short.
    write_reg(lrgd_pkg::REG_ROWS, 48'd48);
    write_reg(lrgd_pkg::REG_FEATS, 48'd1);
    write_reg(lrgd_pkg::REG_ITERS, 48'd1);
    write_reg(lrgd_pkg::REG_GAIN, 48'h0000_1000_0000);
    queue_run();
    drain();

    repeat (64) @(posedge clk_i);
    $display("covered %0d load and %0d run transactions, %0d coefficient results checked",
             load_count, run_count, result_count);
    $display("settings ranged over zero and clamped counts, zero iterations and gain extremes");
    if (mismatch_count == 0 && expected_coefs.size() == 0) begin
      $display("tb_linear_regression_gradient_descent: PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_count, expected_coefs.size());
      $display("tb_linear_regression_gradient_descent: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/lrgd_pkg.sv
hdl/lrgd_ram.sv
hdl/linear_regression_gradient_descent.sv
verif/tb_linear_regression_gradient_descent.sv
